/* rtl/pss_pkg.sv */
// Package for the power switch supervisor: codes, configuration and item types.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

    // Board size: components at or above this index do not exist.
    localparam int NUM_COMP = 64;
    localparam logic [63:0] BOARD_MASK =
        (NUM_COMP >= 64) ? {64{1'b1}} : ((64'd1 << NUM_COMP) - 64'd1);

    // Limit table geometry, fixed by the 6-bit component field.
    localparam int LIM_AW    = 6;
    localparam int LIM_DEPTH = 1 << LIM_AW;

    // Reset values of the limit defaults; the table is loaded with them at reset.
    localparam logic [7:0] V_LIMIT_RST = 8'd0;
    localparam logic [7:0] I_LIMIT_RST = 8'd0;

    localparam logic [6:0] PCT_MAX         = 7'd100;
    localparam logic [6:0] SHUNT_PCT_RST   = 7'd100;

    typedef enum logic [3:0] {
        CMD_ON       = 4'd0,
        CMD_OFF      = 4'd1,
        CMD_CYCLE    = 4'd2,
        CMD_TORQUE   = 4'd3,
        CMD_TELEM    = 4'd4,
        CMD_FORCE_ON = 4'd5,
        CMD_SET_V    = 4'd6,
        CMD_SET_I    = 4'd7
    } cmd_e;

    typedef enum logic [2:0] {
        KIND_ACK     = 3'd0,
        KIND_TELEM   = 3'd1,
        KIND_INVALID = 3'd2,
        KIND_SAFE    = 3'd3,
        KIND_SHUNT   = 3'd4
    } kind_e;

    typedef enum logic [2:0] {
        REG_SWITCHABLE = 3'd0,
        REG_SAFE_OFF   = 3'd1,
        REG_SAFE_PCT   = 3'd2,
        REG_SHUNT_PCT  = 3'd3,
        REG_SHUNT_COMP = 3'd4,
        REG_OVERRIDE   = 3'd5,
        REG_V_DEFAULT  = 3'd6,
        REG_I_DEFAULT  = 3'd7
    } reg_idx_e;

    localparam logic FUNC_COMMAND = 1'b0;
    localparam logic FUNC_CHARGE  = 1'b1;
    localparam logic LINK_NOTICE  = 1'b0;
    localparam logic [3:0] CODE_NONE = 4'd0;

    typedef struct packed {
        logic [63:0] switchable_mask;
        logic [63:0] safe_off_mask;
        logic [6:0]  safe_percent;
        logic [6:0]  shunt_percent;
        logic [5:0]  shunt_component;
        logic        limit_override;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic       link;
        logic [3:0] command;
        logic [5:0] component;
        logic [7:0] limit_value;
        logic [6:0] charge_percent;
    } item_t;

    typedef enum logic [1:0] {
        LIM_SET_V = 2'd0,
        LIM_SET_I = 2'd1,
        LIM_FORCE = 2'd2
    } lim_op_e;

    // Read-modify-write request towards the limit store.
    typedef struct packed {
        logic              valid;
        lim_op_e           op;
        logic [LIM_AW-1:0] addr;
        logic [7:0]        value;
    } lim_req_t;

    typedef struct packed {
        logic       forced;
        logic [7:0] i_limit;
        logic [7:0] v_limit;
    } lim_entry_t;

    localparam lim_entry_t LIM_ENTRY_RST = '{forced: 1'b0, i_limit: I_LIMIT_RST,
                                            v_limit: V_LIMIT_RST};

endpackage

`default_nettype wire

/* rtl/pss_limit_store.sv */
// Per-component store: forced flag, voltage and current limit in one synchronous RAM.
// Read at acceptance, merged and written back in the following cycle. Depends on pss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pss_limit_store (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pss_pkg::lim_req_t req
);

    pss_pkg::lim_entry_t                 mem [pss_pkg::LIM_DEPTH];
    pss_pkg::lim_entry_t                 rd_data_reg;
    logic [pss_pkg::LIM_DEPTH-1:0]       vld_reg;
    pss_pkg::lim_req_t                   req_reg;
    logic                                fwd_valid_reg;
    logic [pss_pkg::LIM_AW-1:0]          fwd_addr_reg;
    pss_pkg::lim_entry_t                 fwd_data_reg;
    pss_pkg::lim_entry_t                 old_entry;
    pss_pkg::lim_entry_t                 new_entry;

    // Read port: data registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[req.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg       <= '0;
            fwd_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            req_reg       <= req;
            fwd_valid_reg <= req_reg.valid;
            if (req_reg.valid)
            begin
                vld_reg[req_reg.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg  <= req_reg.addr;
        fwd_data_reg  <= new_entry;
    end

    // Merge: the write of the previous cycle is forwarded over stale read data
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == req_reg.addr))
        begin
            old_entry = fwd_data_reg;
        end
        else if (vld_reg[req_reg.addr])
        begin
            old_entry = rd_data_reg;
        end
        else
        begin
            old_entry = pss_pkg::LIM_ENTRY_RST;
        end
        new_entry = old_entry;
        unique case (req_reg.op)
            pss_pkg::LIM_SET_V: new_entry.v_limit = req_reg.value;
            pss_pkg::LIM_SET_I: new_entry.i_limit = req_reg.value;
            pss_pkg::LIM_FORCE: new_entry.forced  = 1'b1;
            default:            new_entry = old_entry;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req_reg.valid)
        begin
            mem[req_reg.addr] <= new_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/pss_switch_core.sv */
// Switch state, safe/shunt flags, command decode and the registered reply stage.
// Issues limit-store requests. Depends on pss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pss_switch_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pss_pkg::cfg_t      cfg,
    input  wire pss_pkg::item_t     item,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    reply_link,
    output logic [2:0]              reply_kind,
    output logic [3:0]              reply_code,
    output logic [63:0]             switch_states,
    output logic                    safe_active,
    output pss_pkg::lim_req_t       lim_req
);

    logic [63:0] on_reg, on_next;
    logic        safe_reg, safe_next;
    logic        safe_sent_reg, safe_sent_next;
    logic        shunt_sent_reg, shunt_sent_next;
    logic        out_valid_reg;
    logic        link_reg;
    logic [2:0]  kind_reg;
    logic [3:0]  code_reg;
    logic [63:0] states_reg;
    logic        safe_out_reg;

    logic        in_fire;
    logic        emit;
    logic        r_link;
    logic [2:0]  r_kind;
    logic [3:0]  r_code;
    logic [63:0] comp_bit;
    logic [63:0] shunt_bit;
    logic        sw;
    logic [6:0]  pct;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign comp_bit  = (64'd1 << item.component) & pss_pkg::BOARD_MASK;
    assign shunt_bit = (64'd1 << cfg.shunt_component) & pss_pkg::BOARD_MASK;
    assign sw        = |(comp_bit & cfg.switchable_mask);
    assign pct       = (item.charge_percent > pss_pkg::PCT_MAX) ? pss_pkg::PCT_MAX
                                                               : item.charge_percent;

    always_comb
    begin
        on_next         = on_reg;
        safe_next       = safe_reg;
        safe_sent_next  = safe_sent_reg;
        shunt_sent_next = shunt_sent_reg;
        emit            = 1'b0;
        r_link          = item.link;
        r_kind          = pss_pkg::KIND_ACK;
        r_code          = item.command;
        lim_req.valid   = 1'b0;
        lim_req.op      = pss_pkg::LIM_SET_V;
        lim_req.addr    = item.component;
        lim_req.value   = item.limit_value;

        if (item.func == pss_pkg::FUNC_COMMAND)
        begin
            unique case (item.command)
                pss_pkg::CMD_ON, pss_pkg::CMD_CYCLE:
                begin
                    if (sw)
                    begin
                        on_next = on_reg | comp_bit;
                    end
                    emit = 1'b1;
                end
                pss_pkg::CMD_OFF:
                begin
                    if (sw)
                    begin
                        on_next = on_reg & ~comp_bit;
                    end
                    emit = 1'b1;
                end
                pss_pkg::CMD_TORQUE:
                begin
                    emit = 1'b1;
                end
                pss_pkg::CMD_TELEM:
                begin
                    emit   = 1'b1;
                    r_kind = pss_pkg::KIND_TELEM;
                    r_code = pss_pkg::CODE_NONE;
                end
                pss_pkg::CMD_FORCE_ON:
                begin
                    if (sw)
                    begin
                        on_next = on_reg | comp_bit;
                    end
                    lim_req.valid = in_fire && sw;
                    lim_req.op    = pss_pkg::LIM_FORCE;
                    emit          = 1'b1;
                end
                pss_pkg::CMD_SET_V:
                begin
                    lim_req.valid = in_fire && sw;
                    lim_req.op    = pss_pkg::LIM_SET_V;
                end
                pss_pkg::CMD_SET_I:
                begin
                    lim_req.valid = in_fire && sw;
                    lim_req.op    = pss_pkg::LIM_SET_I;
                end
                default:
                begin
                    emit   = 1'b1;
                    r_kind = pss_pkg::KIND_INVALID;
                    r_code = pss_pkg::CODE_NONE;
                end
            endcase
        end
        else if (!cfg.limit_override)
        begin
            r_link = pss_pkg::LINK_NOTICE;
            r_code = pss_pkg::CODE_NONE;
            priority if (pct < cfg.safe_percent)
            begin
                safe_next      = 1'b1;
                on_next        = on_reg & ~(cfg.safe_off_mask & pss_pkg::BOARD_MASK);
                emit           = !safe_sent_reg;
                safe_sent_next = 1'b1;
                r_kind         = pss_pkg::KIND_SAFE;
            end
            else if (pct > cfg.shunt_percent)
            begin
                safe_next       = 1'b0;
                on_next         = on_reg | shunt_bit;
                emit            = !shunt_sent_reg;
                shunt_sent_next = 1'b1;
                r_kind          = pss_pkg::KIND_SHUNT;
            end
            else
            begin
                emit = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg         <= '0;
            safe_reg       <= 1'b0;
            safe_sent_reg  <= 1'b0;
            shunt_sent_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                on_reg         <= on_next;
                safe_reg       <= safe_next;
                safe_sent_reg  <= safe_sent_next;
                shunt_sent_reg <= shunt_sent_next;
                out_valid_reg  <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            link_reg     <= r_link;
            kind_reg     <= r_kind;
            code_reg     <= r_code;
            states_reg   <= on_next & pss_pkg::BOARD_MASK;
            safe_out_reg <= safe_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reply_link    = link_reg;
    assign reply_kind    = kind_reg;
    assign reply_code    = code_reg;
    assign switch_states = states_reg;
    assign safe_active   = safe_out_reg;

endmodule

`default_nettype wire

/* rtl/power_switch_supervisor_unit.sv */
// Top level of the power switch supervisor: configuration registers and wiring.
// Instantiates pss_switch_core and pss_limit_store; depends on pss_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Power switch supervisor. Each input transaction is a link command (func 0)
// or a state-of-charge update (func 1). Commands switch a component on, off,
// power-cycle it (ends on) or force it on, and echo an acknowledge on the
// command's link; telemetry and invalid codes get replies of their own; set V
// and set I update that component's limit and give no reply. Without
// limit_override, a charge update below safe_percent clears the safe_off_mask
// components and enters safe mode; one above shunt_percent switches the shunt
// component on and leaves safe mode. Each notice goes out once after reset, on
// link 0. Every reply carries the switch states and safe flag as they stand
// after the command. Rate: one transaction per cycle; the reply sits in an
// output register and is valid the cycle after acceptance, and a new
// transaction is taken while it waits as long as out_ready is high that cycle.
// The switch states live in flip-flops; forced flags and limits sit in a
// 64-entry RAM whose read-modify-write is overlapped across transactions by
// forwarding the last write. The table needs no clearing pass: per-entry valid
// bits supply the reset contents. cfg_ready is always high; the user must write
// configuration only while the block is idle, which it does not enforce. The
// limit defaults are loaded at reset, when they hold their reset value, so
// writing registers 6 and 7 later has no visible effect and they are not kept.
module power_switch_supervisor_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // input transactions
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic        link,
    input  wire logic [3:0]  command,
    input  wire logic [5:0]  component,
    input  wire logic [7:0]  limit_value,
    input  wire logic [6:0]  charge_percent,
    // replies
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             reply_link,
    output logic [2:0]       reply_kind,
    output logic [3:0]       reply_code,
    output logic [63:0]      switch_states,
    output logic             safe_active
);

    pss_pkg::cfg_t     cfg_reg;
    pss_pkg::item_t    item;
    pss_pkg::lim_req_t lim_req;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.switchable_mask <= '0;
            cfg_reg.safe_off_mask   <= '0;
            cfg_reg.safe_percent    <= '0;
            cfg_reg.shunt_percent   <= pss_pkg::SHUNT_PCT_RST;
            cfg_reg.shunt_component <= '0;
            cfg_reg.limit_override  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pss_pkg::REG_SWITCHABLE: cfg_reg.switchable_mask <= cfg_data;
                pss_pkg::REG_SAFE_OFF:   cfg_reg.safe_off_mask   <= cfg_data;
                pss_pkg::REG_SAFE_PCT:   cfg_reg.safe_percent    <= cfg_data[6:0];
                pss_pkg::REG_SHUNT_PCT:  cfg_reg.shunt_percent   <= cfg_data[6:0];
                pss_pkg::REG_SHUNT_COMP: cfg_reg.shunt_component <= cfg_data[5:0];
                pss_pkg::REG_OVERRIDE:   cfg_reg.limit_override  <= cfg_data[0];
                // limit defaults: only their reset value ever reaches the table
                default:                 ;
            endcase
        end
    end

    assign item.func           = func;
    assign item.link           = link;
    assign item.command        = command;
    assign item.component      = component;
    assign item.limit_value    = limit_value;
    assign item.charge_percent = charge_percent;

    pss_switch_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item          (item),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reply_link    (reply_link),
        .reply_kind    (reply_kind),
        .reply_code    (reply_code),
        .switch_states (switch_states),
        .safe_active   (safe_active),
        .lim_req       (lim_req)
    );

    pss_limit_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lim_req)
    );

endmodule

`default_nettype wire

/* rtl/pss_checker.sv */
// Port-level checks for power_switch_supervisor_unit, bound to the top level.
// Depends on pss_pkg for the reply kind, link and code constants.
`timescale 1ns / 1ps
`default_nettype none

module pss_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        reply_link,
    input wire logic [2:0]  reply_kind,
    input wire logic [3:0]  reply_code,
    input wire logic [63:0] switch_states,
    input wire logic        safe_active
);

    // A pending reply holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reply_kind)
            && $stable(switch_states))
        else $error("reply dropped or changed while stalled");

    // Empty output stage never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (reply_kind == pss_pkg::KIND_SAFE || reply_kind == pss_pkg::KIND_SHUNT)
        |-> reply_link == pss_pkg::LINK_NOTICE && reply_code == pss_pkg::CODE_NONE)
        else $error("notice not on link 0 with code 0");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind == pss_pkg::KIND_SAFE |-> safe_active)
        else $error("safe notice without safe mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind == pss_pkg::KIND_SHUNT |-> !safe_active)
        else $error("shunt notice while in safe mode");

endmodule

bind power_switch_supervisor_unit pss_checker u_pss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reply_link    (reply_link),
    .reply_kind    (reply_kind),
    .reply_code    (reply_code),
    .switch_states (switch_states),
    .safe_active   (safe_active)
);

`default_nettype wire

/* bench/pss_reply_checker.sv */
// Reply checker for the power switch supervisor: watches the configuration, input and
// reply channels, predicts each reply and compares it field by field.
// Depends on pss_pkg for the item layout, codes and board constants.
`timescale 1ns / 1ps

module pss_reply_checker
    import pss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic        link,
    input  logic [3:0]  command,
    input  logic [5:0]  component,
    input  logic [7:0]  limit_value,
    input  logic [6:0]  charge_percent,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        reply_link,
    input  logic [2:0]  reply_kind,
    input  logic [3:0]  reply_code,
    input  logic [63:0] switch_states,
    input  logic        safe_active,
    output int          n_errors,
    output int          n_pending
);

    typedef struct {
        logic        link;
        kind_e       kind;
        logic [3:0]  code;
        logic [63:0] states;
        logic        safe;
    } reply_t;

    cfg_t        cfg;
    logic [7:0]  v_default;
    logic [7:0]  i_default;
    logic [63:0] on_bits;
    logic [63:0] forced_bits;
    logic [7:0]  v_limits [LIM_DEPTH];
    logic [7:0]  i_limits [LIM_DEPTH];
    logic        safe_flag;
    logic        safe_told;
    logic        shunt_told;
    reply_t      replies_due [$];
    int          err_count = 0;

    function automatic logic [63:0] comp_mask(input logic [5:0] idx);
        return (idx < NUM_COMP) ? (64'd1 << idx) : 64'd0;
    endfunction

    task automatic compare(input string name, input logic [63:0] exp_v,
                           input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Applies one accepted transaction to the local state and queues its reply, if any.
    task automatic apply_item(input item_t it);
        logic [63:0] sel;
        logic        sw;
        logic [6:0]  pct;
        logic        has_reply;
        reply_t      r;
        sel = comp_mask(it.component);
        sw = |(sel & cfg.switchable_mask & BOARD_MASK);
        has_reply = 1'b0;
        r.link = it.link;
        r.code = CODE_NONE;
        r.kind = KIND_ACK;
        if (it.func == FUNC_COMMAND)
        begin
            has_reply = 1'b1;
            case (it.command)
                CMD_ON, CMD_CYCLE:
                begin
                    if (sw) on_bits |= sel;
                    r.code = it.command;
                end
                CMD_OFF:
                begin
                    if (sw) on_bits &= ~sel;
                    r.code = it.command;
                end
                CMD_TORQUE: r.code = it.command;
                CMD_TELEM:  r.kind = KIND_TELEM;
                CMD_FORCE_ON:
                begin
                    if (sw)
                    begin
                        on_bits |= sel;
                        forced_bits |= sel;
                    end
                    r.code = it.command;
                end
                CMD_SET_V:
                begin
                    if (sw) v_limits[it.component] = it.limit_value;
                    has_reply = 1'b0;
                end
                CMD_SET_I:
                begin
                    if (sw) i_limits[it.component] = it.limit_value;
                    has_reply = 1'b0;
                end
                default: r.kind = KIND_INVALID;
            endcase
        end
        else if (!cfg.limit_override)
        begin
            pct = (it.charge_percent > PCT_MAX) ? PCT_MAX : it.charge_percent;
            r.link = LINK_NOTICE;
            if (pct < cfg.safe_percent)
            begin
                safe_flag = 1'b1;
                on_bits &= ~(cfg.safe_off_mask & BOARD_MASK);
                r.kind = KIND_SAFE;
                has_reply = !safe_told;
                safe_told = 1'b1;
            end
            else if (pct > cfg.shunt_percent)
            begin
                safe_flag = 1'b0;
                on_bits |= comp_mask(cfg.shunt_component);
                r.kind = KIND_SHUNT;
                has_reply = !shunt_told;
                shunt_told = 1'b1;
            end
        end
        if (has_reply)
        begin
            r.states = on_bits & BOARD_MASK;
            r.safe = safe_flag;
            replies_due.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t due;
        item_t  cur;
        if (!rst_n)
        begin
            cfg.switchable_mask = '0;
            cfg.safe_off_mask   = '0;
            cfg.safe_percent    = '0;
            cfg.shunt_percent   = SHUNT_PCT_RST;
            cfg.shunt_component = '0;
            cfg.limit_override  = 1'b0;
            v_default   = V_LIMIT_RST;
            i_default   = I_LIMIT_RST;
            on_bits     = '0;
            forced_bits = '0;
            for (int i = 0; i < LIM_DEPTH; i++)
            begin
                v_limits[i] = V_LIMIT_RST;
                i_limits[i] = I_LIMIT_RST;
            end
            safe_flag  = 1'b0;
            safe_told  = 1'b0;
            shunt_told = 1'b0;
            replies_due.delete();
        end
        else
        begin
            // a reply taken at this edge always belongs to an earlier transaction
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    err_count++;
                    $display("%0t: reply with none expected, got kind %0d code %0d",
                             $time, reply_kind, reply_code);
                end
                else
                begin
                    due = replies_due.pop_front();
                    compare("reply_link", 64'(due.link), 64'(reply_link));
                    compare("reply_kind", 64'(due.kind), 64'(reply_kind));
                    compare("reply_code", 64'(due.code), 64'(reply_code));
                    compare("switch_states", due.states, switch_states);
                    compare("safe_active", 64'(due.safe), 64'(safe_active));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SWITCHABLE: cfg.switchable_mask = cfg_data;
                    REG_SAFE_OFF:   cfg.safe_off_mask   = cfg_data;
                    REG_SAFE_PCT:   cfg.safe_percent    = cfg_data[6:0];
                    REG_SHUNT_PCT:  cfg.shunt_percent   = cfg_data[6:0];
                    REG_SHUNT_COMP: cfg.shunt_component = cfg_data[5:0];
                    REG_OVERRIDE:   cfg.limit_override  = cfg_data[0];
                    REG_V_DEFAULT:  v_default           = cfg_data[7:0];
                    REG_I_DEFAULT:  i_default           = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                cur = {func, link, command, component, limit_value, charge_percent};
                apply_item(cur);
            end
        end
        n_errors  <= err_count;
        n_pending <= replies_due.size();
    end

endmodule

/* bench/power_switch_supervisor_unit_tb.sv */
// Testbench top for the power switch supervisor: clock, reset, configuration phases,
// directed and random transactions, reply back-pressure and the verdict.
// Depends on pss_pkg, power_switch_supervisor_unit and pss_reply_checker.
`timescale 1ns / 1ps

module power_switch_supervisor_unit_tb;
    import pss_pkg::*;

    // Invalid command codes have no name in the package.
    localparam logic [3:0] CMD_BAD_LO = 4'd8;
    localparam logic [3:0] CMD_BAD_HI = 4'd15;

    // Cycles left for the limit store read-modify-write to settle once the
    // last reply is in; set V and set I transactions give no reply.
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 250;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic        link;
    logic [3:0]  command;
    logic [5:0]  component;
    logic [7:0]  limit_value;
    logic [6:0]  charge_percent;
    logic        out_valid;
    logic        out_ready;
    logic        reply_link;
    logic [2:0]  reply_kind;
    logic [3:0]  reply_code;
    logic [63:0] switch_states;
    logic        safe_active;
    int          n_errors;
    int          n_pending;

    // Chance, in percent, that a transaction or a reply slot is preceded by
    // a burst of idle cycles of random length. Set per phase; zero in the last one.
    int in_idle_pct  = 0;
    int out_stall_pct = 0;

    power_switch_supervisor_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .link           (link),
        .command        (command),
        .component      (component),
        .limit_value    (limit_value),
        .charge_percent (charge_percent),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reply_link     (reply_link),
        .reply_kind     (reply_kind),
        .reply_code     (reply_code),
        .switch_states  (switch_states),
        .safe_active    (safe_active)
    );

    pss_reply_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .link           (link),
        .command        (command),
        .component      (component),
        .limit_value    (limit_value),
        .charge_percent (charge_percent),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reply_link     (reply_link),
        .reply_kind     (reply_kind),
        .reply_code     (reply_code),
        .switch_states  (switch_states),
        .safe_active    (safe_active),
        .n_errors       (n_errors),
        .n_pending      (n_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (about 1300 transactions,
    // each with its worst-case idle burst, reply stall and latency).
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reply back-pressure. out_ready only moves on falling edges; a stall
    // burst always ends with out_ready raised again before another can begin.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < out_stall_pct)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_ready = 1'b1;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // Link command; the charge field carries noise, which the block ignores.
    function automatic item_t link_cmd(input logic lnk, input logic [3:0] code,
                                       input logic [5:0] comp, input logic [7:0] lim);
        item_t it;
        it.func           = FUNC_COMMAND;
        it.link           = lnk;
        it.command        = code;
        it.component      = comp;
        it.limit_value    = lim;
        it.charge_percent = 7'($urandom_range(0, 127));
        return it;
    endfunction

    // State-of-charge update; command fields carry noise.
    function automatic item_t soc_update(input logic [6:0] pct);
        item_t it;
        it.func           = FUNC_CHARGE;
        it.link           = 1'($urandom_range(0, 1));
        it.command        = 4'($urandom_range(0, 15));
        it.component      = 6'($urandom_range(0, 63));
        it.limit_value    = 8'($urandom_range(0, 255));
        it.charge_percent = pct;
        return it;
    endfunction

    // Mostly valid commands, some invalid codes, about a third charge updates
    // over the full 7-bit range so that saturation above 100 is exercised.
    function automatic item_t rand_item();
        logic [3:0] code;
        if ($urandom_range(0, 99) < 65)
        begin
            if ($urandom_range(0, 9) < 8)
                code = 4'($urandom_range(CMD_ON, CMD_SET_I));
            else
                code = 4'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
            return link_cmd(1'($urandom_range(0, 1)), code, 6'($urandom_range(0, 63)),
                            8'($urandom_range(0, 255)));
        end
        return soc_update(7'($urandom_range(0, 127)));
    endfunction

    // One input transaction. valid is left high after acceptance so that a
    // back-to-back transaction only changes the payload at the next falling edge.
    task automatic send(input item_t it);
        @(negedge clk);
        if ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        func           = it.func;
        link           = it.link;
        command        = it.command;
        component      = it.component;
        limit_value    = it.limit_value;
        charge_percent = it.charge_percent;
        in_valid       = 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid, wait for every expected reply, then let the limit store settle.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (n_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes all eight registers back to back; only called with the block idle.
    task automatic write_regs(input logic [63:0] sw_mask, input logic [63:0] off_mask,
                              input logic [6:0] safe_pct, input logic [6:0] shunt_pct,
                              input logic [5:0] shunt_comp, input logic override,
                              input logic [7:0] v_def, input logic [7:0] i_def);
        logic [63:0] vals [8];
        vals[REG_SWITCHABLE] = sw_mask;
        vals[REG_SAFE_OFF]   = off_mask;
        vals[REG_SAFE_PCT]   = {57'd0, safe_pct};
        vals[REG_SHUNT_PCT]  = {57'd0, shunt_pct};
        vals[REG_SHUNT_COMP] = {58'd0, shunt_comp};
        vals[REG_OVERRIDE]   = {63'd0, override};
        vals[REG_V_DEFAULT]  = {56'd0, v_def};
        vals[REG_I_DEFAULT]  = {56'd0, i_def};
        @(negedge clk);
        for (int i = REG_SWITCHABLE; i <= REG_I_DEFAULT; i++)
        begin
            cfg_valid = 1'b1;
            cfg_index = i[2:0];
            cfg_data  = vals[i];
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int n);
        repeat (n) send(rand_item());
        drain();
    endtask

    initial
    begin : stimulus
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_SWITCHABLE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        func           = FUNC_COMMAND;
        link           = 1'b0;
        command        = CMD_ON;
        component      = '0;
        limit_value    = '0;
        charge_percent = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Components 0..3 and 63 have no switch; the shunt
        // component 63 is switched on all the same by a shunt condition.
        in_idle_pct   = 30;
        out_stall_pct = 30;
        write_regs(64'h7FFF_FFFF_FFFF_FFF0, 64'hFFFF_0000_0000_FFFF, 7'd50, 7'd80,
                   6'd63, 1'b0, 8'd255, 8'd128);
        send(link_cmd(1'b0, CMD_ON, 6'd5, 8'd0));
        send(link_cmd(1'b1, CMD_ON, 6'd0, 8'd0));        // no switch there
        send(link_cmd(1'b0, CMD_CYCLE, 6'd62, 8'd0));
        send(link_cmd(1'b1, CMD_FORCE_ON, 6'd10, 8'd0));
        send(link_cmd(1'b0, CMD_OFF, 6'd5, 8'd0));
        send(link_cmd(1'b0, CMD_TORQUE, 6'd33, 8'd0));
        send(link_cmd(1'b1, CMD_TELEM, 6'd63, 8'd255));
        send(link_cmd(1'b0, CMD_SET_V, 6'd10, 8'd255));
        send(link_cmd(1'b1, CMD_SET_I, 6'd0, 8'd0));
        send(link_cmd(1'b0, CMD_BAD_LO, 6'd7, 8'd1));
        send(link_cmd(1'b1, CMD_BAD_HI, 6'd63, 8'd170));
        send(soc_update(7'd50));                          // equal to safe threshold
        send(soc_update(7'd80));                          // equal to shunt threshold
        send(soc_update(7'd10));                          // first safe entry: notice
        send(link_cmd(1'b1, CMD_ON, 6'd40, 8'd0));
        send(soc_update(7'd0));                           // safe again, no notice
        send(soc_update(7'd127));                         // saturates to 100: shunt notice
        send(soc_update(7'd81));                          // shunt again, no notice
        send(link_cmd(1'b1, CMD_ON, 6'd63, 8'd0));
        send(link_cmd(1'b0, CMD_ON, 6'd20, 8'd85));
        drain();

        // Random thresholds and masks.
        in_idle_pct   = 20;
        out_stall_pct = 0;
        write_regs({$urandom, $urandom}, {$urandom, $urandom}, 7'($urandom_range(0, 100)),
                   7'($urandom_range(0, 100)), 6'($urandom_range(0, 63)), 1'b0,
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(ITEMS_PER_PHASE);

        // All switchable, safe mode never entered, shunt at 100 so that a
        // saturated percent must not trip it.
        in_idle_pct   = 0;
        out_stall_pct = 40;
        write_regs({64{1'b1}}, '0, 7'd0, PCT_MAX, 6'd0, 1'b0, 8'd0, 8'd0);
        run_random(ITEMS_PER_PHASE);

        // Nothing switchable and charge updates overridden.
        in_idle_pct   = 40;
        out_stall_pct = 40;
        write_regs('0, {64{1'b1}}, PCT_MAX, 7'd0, 6'd63, 1'b1, 8'd255, 8'd255);
        run_random(ITEMS_PER_PHASE);

        // Out-of-range thresholds: every charge update is below the safe one.
        in_idle_pct   = 25;
        out_stall_pct = 25;
        write_regs({$urandom, $urandom}, {64{1'b1}}, 7'd127, 7'd127,
                   6'($urandom_range(0, 63)), 1'b0, 8'd128, 8'd1);
        run_random(ITEMS_PER_PHASE);

        // Final stretch at full rate: any nonzero charge trips the shunt.
        in_idle_pct   = 0;
        out_stall_pct = 0;
        write_regs({$urandom, $urandom}, {$urandom, $urandom}, 7'd0, 7'd0,
                   6'($urandom_range(0, 63)), 1'b0, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        run_random(ITEMS_PER_PHASE);

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
